### src/aspc_pkg.sv
`default_nettype none

package aspc_pkg;

    // Fixed-point angle format: unit one degree, 16 fractional bits
    localparam int FRAC_BITS   = 16;
    localparam int GUARD_BITS  = 16;
    localparam int ANGLE_REG_W = 9;
    localparam int ANG_W       = ANGLE_REG_W + FRAC_BITS;
    localparam int ZW          = 24;
    localparam int ATAN_W      = 22;
    localparam int COLOR_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [ANGLE_REG_W-1:0] ANGLE_MAX = 9'd360;

    localparam logic [ANG_W-1:0] DEG45  = ANG_W'(45)  << FRAC_BITS;
    localparam logic [ANG_W-1:0] DEG90  = ANG_W'(90)  << FRAC_BITS;
    localparam logic [ANG_W-1:0] DEG180 = ANG_W'(180) << FRAC_BITS;
    localparam logic [ANG_W-1:0] DEG360 = ANG_W'(360) << FRAC_BITS;

    // Octant clamp bounds in the signed CORDIC angle format
    localparam logic signed [ZW-1:0] Z_LO_MIN = ZW'(1);
    localparam logic signed [ZW-1:0] Z_LO_MAX = ZW'((45 << FRAC_BITS) - 1);
    localparam logic signed [ZW-1:0] Z_HI_MIN = ZW'((45 << FRAC_BITS) + 1);
    localparam logic signed [ZW-1:0] Z_HI_MAX = ZW'((90 << FRAC_BITS) - 1);

    // atan(2^-i) in degrees, scaled by 2^16 and rounded
    localparam logic [ATAN_W-1:0] ATAN_TABLE [0:31] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_ARC_RADIUS,
        REG_START_ANGLE,
        REG_END_ANGLE,
        REG_FILLED_MODE,
        REG_DRAW_COLOR
    } cfg_index_t;

    typedef enum logic [1:0] {
        Q_FIRST,
        Q_SECOND,
        Q_THIRD,
        Q_FOURTH
    } quad_t;

    // Directions decided exactly, without the CORDIC result
    typedef enum logic [1:0] {
        SP_NONE,
        SP_ZERO,
        SP_RIGHT,
        SP_DIAG
    } special_t;

    typedef struct packed {
        quad_t    quad;
        special_t special;
        logic     octant_lo;
        logic     dist_ok;
    } ctrl_t;

endpackage

`default_nettype wire

### src/aspc_cordic_cell.sv
`default_nettype none

module aspc_cordic_cell
    import aspc_pkg::*;
#(
    parameter int COORD_WIDTH = 12,
    parameter int STAGE       = 0
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         valid_in,
    input  wire ctrl_t                                        ctrl_in,
    input  wire logic [COORD_WIDTH-1:0]                       px_in,
    input  wire logic [COORD_WIDTH-1:0]                       py_in,
    input  wire logic signed [COORD_WIDTH+GUARD_BITS+3:0]     x_in,
    input  wire logic signed [COORD_WIDTH+GUARD_BITS+3:0]     y_in,
    input  wire logic signed [ZW-1:0]                         z_in,
    output logic                                              valid_out,
    output ctrl_t                                             ctrl_out,
    output logic [COORD_WIDTH-1:0]                            px_out,
    output logic [COORD_WIDTH-1:0]                            py_out,
    output logic signed [COORD_WIDTH+GUARD_BITS+3:0]          x_out,
    output logic signed [COORD_WIDTH+GUARD_BITS+3:0]          y_out,
    output logic signed [ZW-1:0]                              z_out
);

    localparam int XW = COORD_WIDTH + GUARD_BITS + 4;
    localparam logic signed [ZW-1:0] ANGLE_STEP = ZW'(ATAN_TABLE[STAGE]);

    logic                  valid_reg;
    ctrl_t                 ctrl_reg;
    logic [COORD_WIDTH-1:0] px_reg;
    logic [COORD_WIDTH-1:0] py_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [XW-1:0]  y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic signed [XW-1:0]  x_next;
    logic signed [XW-1:0]  y_next;
    logic signed [ZW-1:0]  z_next;

    // Rotate toward the x axis by one micro-angle
    always_comb
    begin
        if (!y_in[XW-1])
        begin
            x_next = x_in + (y_in >>> STAGE);
            y_next = y_in - (x_in >>> STAGE);
            z_next = z_in + ANGLE_STEP;
        end
        else
        begin
            x_next = x_in - (y_in >>> STAGE);
            y_next = y_in + (x_in >>> STAGE);
            z_next = z_in - ANGLE_STEP;
        end
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Hand the vector and the pixel data to the next cell
    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_in;
        px_reg   <= px_in;
        py_reg   <= py_in;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign valid_out = valid_reg;
    assign ctrl_out  = ctrl_reg;
    assign px_out    = px_reg;
    assign py_out    = py_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

`default_nettype wire

### src/aspc_front.sv
`default_nettype none

module aspc_front
    import aspc_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [COORD_WIDTH-1:0]       pixel_x,
    input  wire logic [COORD_WIDTH-1:0]       pixel_y,
    input  wire logic signed [COORD_WIDTH:0]  center_x,
    input  wire logic signed [COORD_WIDTH:0]  center_y,
    input  wire logic [COORD_WIDTH-1:0]       arc_radius,
    input  wire logic                         filled_mode,
    output logic                              valid_out,
    output ctrl_t                             ctrl_out,
    output logic [COORD_WIDTH-1:0]            px_out,
    output logic [COORD_WIDTH-1:0]            py_out,
    output logic [COORD_WIDTH:0]              ax_out,
    output logic [COORD_WIDTH:0]              ay_out
);

    localparam int DW = COORD_WIDTH + 2;
    localparam int AW = COORD_WIDTH + 1;
    localparam int RW = 2 * COORD_WIDTH;
    localparam int SW = 2 * AW;
    localparam int D2W = SW + 1;

    // Stage A: offsets from the center
    logic                   a_valid_reg;
    logic [COORD_WIDTH-1:0] a_px_reg;
    logic [COORD_WIDTH-1:0] a_py_reg;
    logic signed [DW-1:0]   a_dx_reg;
    logic signed [DW-1:0]   a_dy_reg;

    // Stage B: magnitudes, quadrant, squares
    logic                   b_valid_reg;
    logic [COORD_WIDTH-1:0] b_px_reg;
    logic [COORD_WIDTH-1:0] b_py_reg;
    logic [AW-1:0]          b_ax_reg;
    logic [AW-1:0]          b_ay_reg;
    quad_t                  b_quad_reg;
    logic [SW-1:0]          b_sqx_reg;
    logic [SW-1:0]          b_sqy_reg;

    // Stage C: distance verdict and exact directions
    logic                   c_valid_reg;
    ctrl_t                  c_ctrl_reg;
    logic [COORD_WIDTH-1:0] c_px_reg;
    logic [COORD_WIDTH-1:0] c_py_reg;
    logic [AW-1:0]          c_ax_reg;
    logic [AW-1:0]          c_ay_reg;

    // Radius bounds, refreshed from the registers every cycle
    logic [RW-1:0]          r2_reg;
    logic [RW-1:0]          low_reg;

    logic signed [DW-1:0]   dx_next;
    logic signed [DW-1:0]   dy_next;
    logic signed [DW-1:0]   abs_x;
    logic signed [DW-1:0]   abs_y;
    logic signed [2*DW-1:0] prod_x;
    logic signed [2*DW-1:0] prod_y;
    quad_t                  quad_next;
    logic [D2W-1:0]         d2;
    logic                   dist_next;
    special_t               special_next;
    ctrl_t                  ctrl_next;
    logic [COORD_WIDTH-1:0] r_minus;
    logic [RW-1:0]          r2_next;
    logic [RW-1:0]          low_next;

    // Offsets
    assign dx_next = $signed({2'b00, pixel_x}) - DW'(center_x);
    assign dy_next = $signed({2'b00, pixel_y}) - DW'(center_y);

    // Magnitudes and squares
    assign abs_x  = a_dx_reg[DW-1] ? -a_dx_reg : a_dx_reg;
    assign abs_y  = a_dy_reg[DW-1] ? -a_dy_reg : a_dy_reg;
    assign prod_x = a_dx_reg * a_dx_reg;
    assign prod_y = a_dy_reg * a_dy_reg;

    // Pick the quadrant; the center itself maps to angle zero
    always_comb
    begin
        if ((a_dx_reg > 0) && (a_dy_reg >= 0))
        begin
            quad_next = Q_FIRST;
        end
        else if ((a_dx_reg <= 0) && (a_dy_reg > 0))
        begin
            quad_next = Q_SECOND;
        end
        else if ((a_dx_reg < 0) && (a_dy_reg <= 0))
        begin
            quad_next = Q_THIRD;
        end
        else if (a_dy_reg < 0)
        begin
            quad_next = Q_FOURTH;
        end
        else
        begin
            quad_next = Q_FIRST;
        end
    end

    // Test the squared distance against the ring
    assign d2        = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
    assign dist_next = (d2 <= D2W'(r2_reg)) && (d2 >= D2W'(low_reg));

    // Decide axis and diagonal directions exactly
    always_comb
    begin
        if (b_ay_reg == '0)
        begin
            special_next = SP_ZERO;
        end
        else if (b_ax_reg == '0)
        begin
            special_next = SP_RIGHT;
        end
        else if (b_ax_reg == b_ay_reg)
        begin
            special_next = SP_DIAG;
        end
        else
        begin
            special_next = SP_NONE;
        end
    end

    always_comb
    begin
        ctrl_next.quad      = b_quad_reg;
        ctrl_next.special   = special_next;
        ctrl_next.octant_lo = (b_ay_reg < b_ax_reg);
        ctrl_next.dist_ok   = dist_next;
    end

    // Inner bound: none for a filled sector or a zero radius
    assign r_minus  = arc_radius - COORD_WIDTH'(1);
    assign r2_next  = arc_radius * arc_radius;
    assign low_next = (filled_mode || (arc_radius == '0)) ? '0 : r_minus * r_minus;

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        a_px_reg   <= pixel_x;
        a_py_reg   <= pixel_y;
        a_dx_reg   <= dx_next;
        a_dy_reg   <= dy_next;

        b_px_reg   <= a_px_reg;
        b_py_reg   <= a_py_reg;
        b_ax_reg   <= abs_x[AW-1:0];
        b_ay_reg   <= abs_y[AW-1:0];
        b_quad_reg <= quad_next;
        b_sqx_reg  <= prod_x[SW-1:0];
        b_sqy_reg  <= prod_y[SW-1:0];

        c_ctrl_reg <= ctrl_next;
        c_px_reg   <= b_px_reg;
        c_py_reg   <= b_py_reg;
        c_ax_reg   <= b_ax_reg;
        c_ay_reg   <= b_ay_reg;

        r2_reg     <= r2_next;
        low_reg    <= low_next;
    end

    assign valid_out = c_valid_reg;
    assign ctrl_out  = c_ctrl_reg;
    assign px_out    = c_px_reg;
    assign py_out    = c_py_reg;
    assign ax_out    = c_ax_reg;
    assign ay_out    = c_ay_reg;

endmodule

`default_nettype wire

### src/aspc_back.sv
`default_nettype none

module aspc_back
    import aspc_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     valid_in,
    input  wire ctrl_t                    ctrl_in,
    input  wire logic [COORD_WIDTH-1:0]   px_in,
    input  wire logic [COORD_WIDTH-1:0]   py_in,
    input  wire logic signed [ZW-1:0]     z_in,
    input  wire logic [ANGLE_REG_W-1:0]   start_angle,
    input  wire logic [ANGLE_REG_W-1:0]   end_angle,
    input  wire logic [COLOR_W-1:0]       draw_color,
    output logic                          done,
    output logic [COORD_WIDTH-1:0]        out_x,
    output logic [COORD_WIDTH-1:0]        out_y,
    output logic                          write_enable,
    output logic [COLOR_W-1:0]            pixel_value
);

    // Stage 1: quadrant angle
    logic                   q_valid_reg;
    quad_t                  q_quad_reg;
    logic                   q_dist_reg;
    logic [COORD_WIDTH-1:0] q_px_reg;
    logic [COORD_WIDTH-1:0] q_py_reg;
    logic [ANG_W-1:0]       q_reg;

    // Stage 2: full angle
    logic                   f_valid_reg;
    logic                   f_dist_reg;
    logic [COORD_WIDTH-1:0] f_px_reg;
    logic [COORD_WIDTH-1:0] f_py_reg;
    logic [ANG_W-1:0]       a_reg;

    // Stage 3: result beat
    logic                   done_reg;
    logic [COORD_WIDTH-1:0] out_x_reg;
    logic [COORD_WIDTH-1:0] out_y_reg;
    logic                   we_reg;
    logic [COLOR_W-1:0]     value_reg;

    logic signed [ZW-1:0]   z_clamped;
    logic [ANG_W-1:0]       q_next;
    logic [ANG_W-1:0]       a_next;
    logic [ANG_W-1:0]       lo_bound;
    logic [ANG_W-1:0]       hi_bound;
    logic                   hit;

    // Clamp the CORDIC angle into the open octant
    always_comb
    begin
        if (ctrl_in.octant_lo)
        begin
            if (z_in < Z_LO_MIN)
            begin
                z_clamped = Z_LO_MIN;
            end
            else if (z_in > Z_LO_MAX)
            begin
                z_clamped = Z_LO_MAX;
            end
            else
            begin
                z_clamped = z_in;
            end
        end
        else
        begin
            if (z_in < Z_HI_MIN)
            begin
                z_clamped = Z_HI_MIN;
            end
            else if (z_in > Z_HI_MAX)
            begin
                z_clamped = Z_HI_MAX;
            end
            else
            begin
                z_clamped = z_in;
            end
        end
    end

    // Use exact angles on axes and diagonals
    always_comb
    begin
        case (ctrl_in.special)
            SP_ZERO:  q_next = '0;
            SP_RIGHT: q_next = DEG90;
            SP_DIAG:  q_next = DEG45;
            default:  q_next = ANG_W'($unsigned(z_clamped));
        endcase
    end

    // Unfold the quadrant angle to the full circle
    always_comb
    begin
        case (q_quad_reg)
            Q_FIRST:  a_next = q_reg;
            Q_SECOND: a_next = DEG180 - q_reg;
            Q_THIRD:  a_next = DEG180 + q_reg;
            Q_FOURTH: a_next = DEG360 - q_reg;
            default:  a_next = q_reg;
        endcase
    end

    // Compare against the mirrored sector bounds
    assign lo_bound = {ANGLE_MAX - end_angle, {FRAC_BITS{1'b0}}};
    assign hi_bound = {ANGLE_MAX - start_angle, {FRAC_BITS{1'b0}}};
    assign hit      = f_valid_reg && f_dist_reg && (a_reg >= lo_bound) && (a_reg <= hi_bound);

    // Advance the valid flags and the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
            we_reg      <= 1'b0;
        end
        else
        begin
            q_valid_reg <= valid_in;
            f_valid_reg <= q_valid_reg;
            done_reg    <= f_valid_reg;
            we_reg      <= hit;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        q_quad_reg <= ctrl_in.quad;
        q_dist_reg <= ctrl_in.dist_ok;
        q_px_reg   <= px_in;
        q_py_reg   <= py_in;
        q_reg      <= q_next;

        f_dist_reg <= q_dist_reg;
        f_px_reg   <= q_px_reg;
        f_py_reg   <= q_py_reg;
        a_reg      <= a_next;

        out_x_reg  <= f_px_reg;
        out_y_reg  <= f_py_reg;
        value_reg  <= hit ? draw_color : '0;
    end

    assign done         = done_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign write_enable = we_reg;
    assign pixel_value  = value_reg;

endmodule

`default_nettype wire

### src/arc_sector_pixel_classifier_unit.sv
// Throughput: one pixel per clock; busy never rises, the CORDIC cell chain is fully pipelined.
// Three front stages (offset, square, distance test), one cell per CORDIC stage, three
// back stages (clamp, unfold, sector test and output register).
// Reset: rst_n clears every stage valid and sets the configuration registers to their reset values.
// The result beat lasts one cycle and cannot be held off by the receiver.
`default_nettype none

module arc_sector_pixel_classifier_unit
    import aspc_pkg::*;
#(
    parameter int COORD_WIDTH   = 12,
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [COORD_WIDTH-1:0]   pixel_x,
    input  wire logic [COORD_WIDTH-1:0]   pixel_y,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    output logic                          done,
    output logic [COORD_WIDTH-1:0]        out_x,
    output logic [COORD_WIDTH-1:0]        out_y,
    output logic                          write_enable,
    output logic [COLOR_W-1:0]            pixel_value
);

    localparam int AW = COORD_WIDTH + 1;
    localparam int XW = COORD_WIDTH + GUARD_BITS + 4;

    logic signed [COORD_WIDTH:0]  center_x_reg;
    logic signed [COORD_WIDTH:0]  center_y_reg;
    logic [COORD_WIDTH-1:0]       arc_radius_reg;
    logic [ANGLE_REG_W-1:0]       start_angle_reg;
    logic [ANGLE_REG_W-1:0]       end_angle_reg;
    logic                         filled_mode_reg;
    logic [COLOR_W-1:0]           draw_color_reg;
    logic [ANGLE_REG_W-1:0]       angle_wr;

    logic                         accept;
    logic [AW-1:0]                front_ax;
    logic [AW-1:0]                front_ay;

    logic                         valid_chain [0:CORDIC_STAGES];
    ctrl_t                        ctrl_chain  [0:CORDIC_STAGES];
    logic [COORD_WIDTH-1:0]       px_chain    [0:CORDIC_STAGES];
    logic [COORD_WIDTH-1:0]       py_chain    [0:CORDIC_STAGES];
    logic signed [XW-1:0]         x_chain     [0:CORDIC_STAGES];
    logic signed [XW-1:0]         y_chain     [0:CORDIC_STAGES];
    logic signed [ZW-1:0]         z_chain     [0:CORDIC_STAGES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Saturate angle writes at 360
    assign angle_wr = (cfg_data[ANGLE_REG_W-1:0] > ANGLE_MAX) ? ANGLE_MAX
                                                              : cfg_data[ANGLE_REG_W-1:0];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            arc_radius_reg  <= '0;
            start_angle_reg <= '0;
            end_angle_reg   <= ANGLE_MAX;
            filled_mode_reg <= 1'b0;
            draw_color_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_CENTER_X:    center_x_reg    <= $signed(cfg_data[COORD_WIDTH:0]);
                REG_CENTER_Y:    center_y_reg    <= $signed(cfg_data[COORD_WIDTH:0]);
                REG_ARC_RADIUS:  arc_radius_reg  <= cfg_data[COORD_WIDTH-1:0];
                REG_START_ANGLE: start_angle_reg <= angle_wr;
                REG_END_ANGLE:   end_angle_reg   <= angle_wr;
                REG_FILLED_MODE: filled_mode_reg <= cfg_data[0];
                REG_DRAW_COLOR:  draw_color_reg  <= cfg_data[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    aspc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .arc_radius  (arc_radius_reg),
        .filled_mode (filled_mode_reg),
        .valid_out   (valid_chain[0]),
        .ctrl_out    (ctrl_chain[0]),
        .px_out      (px_chain[0]),
        .py_out      (py_chain[0]),
        .ax_out      (front_ax),
        .ay_out      (front_ay)
    );

    // Load the vector with guard bits
    assign x_chain[0] = $signed({3'b000, front_ax, {GUARD_BITS{1'b0}}});
    assign y_chain[0] = $signed({3'b000, front_ay, {GUARD_BITS{1'b0}}});
    assign z_chain[0] = '0;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        aspc_cordic_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .STAGE       (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[g]),
            .ctrl_in   (ctrl_chain[g]),
            .px_in     (px_chain[g]),
            .py_in     (py_chain[g]),
            .x_in      (x_chain[g]),
            .y_in      (y_chain[g]),
            .z_in      (z_chain[g]),
            .valid_out (valid_chain[g+1]),
            .ctrl_out  (ctrl_chain[g+1]),
            .px_out    (px_chain[g+1]),
            .py_out    (py_chain[g+1]),
            .x_out     (x_chain[g+1]),
            .y_out     (y_chain[g+1]),
            .z_out     (z_chain[g+1])
        );
    end

    aspc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (valid_chain[CORDIC_STAGES]),
        .ctrl_in      (ctrl_chain[CORDIC_STAGES]),
        .px_in        (px_chain[CORDIC_STAGES]),
        .py_in        (py_chain[CORDIC_STAGES]),
        .z_in         (z_chain[CORDIC_STAGES]),
        .start_angle  (start_angle_reg),
        .end_angle    (end_angle_reg),
        .draw_color   (draw_color_reg),
        .done         (done),
        .out_x        (out_x),
        .out_y        (out_y),
        .write_enable (write_enable),
        .pixel_value  (pixel_value)
    );

endmodule

`default_nettype wire

### src/aspc_checker.sv
`default_nettype none

module aspc_checker
    import aspc_pkg::*;
#(
    parameter int COORD_WIDTH   = 12,
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     busy,
    input  wire logic [COORD_WIDTH-1:0]   pixel_x,
    input  wire logic [COORD_WIDTH-1:0]   pixel_y,
    input  wire logic                     done,
    input  wire logic [COORD_WIDTH-1:0]   out_x,
    input  wire logic [COORD_WIDTH-1:0]   out_y,
    input  wire logic                     write_enable,
    input  wire logic [COLOR_W-1:0]       pixel_value
);

    // Done rises once the accepted pixel has passed the front, cell and back registers, and is
    // sampled at the edge that ends the beat
    localparam int LATENCY = CORDIC_STAGES + 6;

    // A write only comes with a result beat
    a_we_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
        write_enable |-> done)
        else $error("write_enable outside a result beat");

    // A miss carries a zero pixel value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !write_enable) |-> (pixel_value == '0))
        else $error("pixel_value nonzero on a miss");

    // Every result beat goes back to an accepted pixel at fixed latency
    a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching accepted pixel");

    // Coordinates pass through unchanged
    a_coords: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((out_x == $past(pixel_x, LATENCY)) && (out_y == $past(pixel_y, LATENCY))))
        else $error("result coordinates differ from the accepted pixel");

endmodule

bind arc_sector_pixel_classifier_unit aspc_checker #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
) u_aspc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .done         (done),
    .out_x        (out_x),
    .out_y        (out_y),
    .write_enable (write_enable),
    .pixel_value  (pixel_value)
);

`default_nettype wire

### tb/arc_sector_pixel_classifier_unit_tb.sv
`timescale 1ns / 100ps

module arc_sector_pixel_classifier_unit_tb;
    import aspc_pkg::*;

    localparam int     COORD_W       = 12;
    localparam int     CORDIC_DEPTH  = 16;
    localparam int     GUARD         = 16;
    localparam longint DEG_ONE       = 64'd65536;
    localparam int     ANGLE_LIMIT   = 360;
    localparam int     COORD_MAX     = (1 << COORD_W) - 1;
    localparam int     PIPE_LATENCY  = CORDIC_DEPTH + 5;
    localparam int     CYCLE_LIMIT   = 100000;
    localparam int     RANDOM_PHASES = 14;
    localparam int     PHASE_PIXELS  = 125;

    // Index past the end of the register list; writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

    // atan(2^-i) in degrees, 16 fractional bits
    localparam longint ATAN_Q16 [CORDIC_DEPTH] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               we;
        logic [COLOR_W-1:0] value;
    } arc_pixel_t;

    class arc_pixel_checker;
        int                       fails;
        logic signed [COORD_W:0]  ctr_x;
        logic signed [COORD_W:0]  ctr_y;
        logic [COORD_W-1:0]       radius;
        logic [ANGLE_REG_W-1:0]   ang_start;
        logic [ANGLE_REG_W-1:0]   ang_end;
        logic                     fill;
        logic [COLOR_W-1:0]       color;
        arc_pixel_t               expected_pixels[$];

        function new();
            fails     = 0;
            ctr_x     = '0;
            ctr_y     = '0;
            radius    = '0;
            ang_start = '0;
            ang_end   = ANGLE_REG_W'(ANGLE_LIMIT);
            fill      = 1'b0;
            color     = '0;
        endfunction

        // Mirror a register write; angle registers saturate at 360
        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            logic [ANGLE_REG_W-1:0] ang;
            ang = data[ANGLE_REG_W-1:0];
            if (ang > ANGLE_REG_W'(ANGLE_LIMIT))
                ang = ANGLE_REG_W'(ANGLE_LIMIT);
            case (idx)
                REG_CENTER_X:    ctr_x = data[COORD_W:0];
                REG_CENTER_Y:    ctr_y = data[COORD_W:0];
                REG_ARC_RADIUS:  radius = data[COORD_W-1:0];
                REG_START_ANGLE: ang_start = ang;
                REG_END_ANGLE:   ang_end = ang;
                REG_FILLED_MODE: fill = data[0];
                REG_DRAW_COLOR:  color = data[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        // First-quadrant angle of (ax, ay) in degrees with 16 fractional bits
        function longint quad_angle(longint ax, longint ay);
            longint x, y, z, nx, ny, lo, hi;
            if (ay == 0)
                return 0;
            if (ax == 0)
                return 90 * DEG_ONE;
            if (ax == ay)
                return 45 * DEG_ONE;
            x = ax <<< GUARD;
            y = ay <<< GUARD;
            z = 0;
            for (int i = 0; i < CORDIC_DEPTH; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + ATAN_Q16[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - ATAN_Q16[i];
                end
                x = nx;
                y = ny;
            end
            // Hold the result inside the open octant
            if (ay < ax)
            begin
                lo = 1;
                hi = 45 * DEG_ONE - 1;
            end
            else
            begin
                lo = 45 * DEG_ONE + 1;
                hi = 90 * DEG_ONE - 1;
            end
            if (z < lo)
                z = lo;
            if (z > hi)
                z = hi;
            return z;
        endfunction

        // Work out the result for one accepted pixel
        function void note_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
            longint     dx, dy, ax, ay, q, a, d2, r;
            bit         on_arc;
            arc_pixel_t e;
            dx = longint'(px) - longint'(ctr_x);
            dy = longint'(py) - longint'(ctr_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            q  = quad_angle(ax, ay);
            if (dx > 0 && dy >= 0)
                a = q;
            else if (dx <= 0 && dy > 0)
                a = 180 * DEG_ONE - q;
            else if (dx < 0 && dy <= 0)
                a = 180 * DEG_ONE + q;
            else if (dy < 0)
                a = 360 * DEG_ONE - q;
            else
                a = 0;
            on_arc = (a >= (ANGLE_LIMIT - longint'(ang_end)) * DEG_ONE) &&
                     (a <= (ANGLE_LIMIT - longint'(ang_start)) * DEG_ONE);
            // Distance test is exact
            d2 = dx * dx + dy * dy;
            r  = longint'(radius);
            if (fill)
                on_arc = on_arc && (d2 <= r * r);
            else
                on_arc = on_arc && (d2 <= r * r) && (r == 0 || d2 >= (r - 1) * (r - 1));
            e.x     = px;
            e.y     = py;
            e.we    = on_arc;
            e.value = on_arc ? color : '0;
            expected_pixels.push_back(e);
        endfunction

        function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
            fails++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, field, exp_v, act_v);
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic we, logic [COLOR_W-1:0] value);
            arc_pixel_t e;
            if (expected_pixels.size() == 0)
            begin
                report("done (no pixel pending)", 64'd0, 64'd1);
                return;
            end
            e = expected_pixels.pop_front();
            if (x !== e.x)
                report("out_x", 64'(e.x), 64'(x));
            if (y !== e.y)
                report("out_y", 64'(e.y), 64'(y));
            if (we !== e.we)
                report("write_enable", 64'(e.we), 64'(we));
            if (value !== e.value)
                report("pixel_value", 64'(e.value), 64'(value));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [COORD_W-1:0]     pixel_x = '0;
    logic [COORD_W-1:0]     pixel_y = '0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   done;
    logic [COORD_W-1:0]     out_x;
    logic [COORD_W-1:0]     out_y;
    logic                   write_enable;
    logic [COLOR_W-1:0]     pixel_value;
    int                     cycles = 0;

    arc_pixel_checker sb;

    arc_sector_pixel_classifier_unit #(
        .COORD_WIDTH   (COORD_W),
        .CORDIC_STAGES (CORDIC_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .out_x        (out_x),
        .out_y        (out_y),
        .write_enable (write_enable),
        .pixel_value  (pixel_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Note accepted pixel beats and check result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_pixel(pixel_x, pixel_y);
            if (done)
                sb.check_pixel(out_x, out_y, write_enable, pixel_value);
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Hold one register write for a clock; the caller lowers cfg_we
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input int cx, input int cy, input int r, input int sa,
                             input int ea, input bit fill, input logic [31:0] color);
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy));
        write_reg(REG_ARC_RADIUS, 32'(r));
        write_reg(REG_START_ANGLE, 32'(sa));
        write_reg(REG_END_ANGLE, 32'(ea));
        write_reg(REG_FILLED_MODE, 32'(fill));
        write_reg(REG_DRAW_COLOR, color);
        cfg_we <= 1'b0;
    endtask

    // Present one pixel and hold it until accepted; start stays high
    task automatic send_pixel(input int x, input int y);
        start   <= 1'b1;
        pixel_x <= COORD_W'(x);
        pixel_y <= COORD_W'(y);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Wait until every pending pixel has come back, then let the pipe drain
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sb.expected_pixels.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic int on_surface(int v);
        if (v < 0 || v > COORD_MAX)
            return $urandom_range(0, COORD_MAX);
        return v;
    endfunction

    // Random pixels, most of them close to the arc of the current setting
    task automatic random_phase(input int count);
        int cx, cy, r, sa, ea, t, dx, dy, rem, n, burst, gap, pick;
        cx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, COORD_MAX)
                                        : int'($urandom_range(0, 8191)) - 4096;
        cy = ($urandom_range(0, 9) < 7) ? $urandom_range(0, COORD_MAX)
                                        : int'($urandom_range(0, 8191)) - 4096;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r = $urandom_range(0, 64);
            5, 6, 7:       r = $urandom_range(0, 600);
            default:       r = $urandom_range(0, COORD_MAX);
        endcase
        sa = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, ANGLE_LIMIT);
        ea = ($urandom_range(0, 4) == 0) ? ANGLE_LIMIT : $urandom_range(0, ANGLE_LIMIT);
        if (sa > ea && $urandom_range(0, 4) != 0)
        begin
            t  = sa;
            sa = ea;
            ea = t;
        end
        if ($urandom_range(0, 9) == 0)
            ea = $urandom_range(ANGLE_LIMIT + 1, 511);
        configure(cx, cy, r, sa, ea, 1'($urandom_range(0, 1)), $urandom());

        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && n < count; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    // On or just off the ring
                    dx  = int'($urandom_range(0, 2 * r + 2)) - r - 1;
                    rem = r * r - dx * dx;
                    if (rem < 0)
                        rem = 0;
                    dy = int'($sqrt(real'(rem)));
                    if ($urandom_range(0, 1))
                        dy = -dy;
                    dy = dy + int'($urandom_range(0, 2)) - 1;
                end
                else if (pick < 7)
                begin
                    dx = int'($urandom_range(0, 2 * r + 4)) - r - 2;
                    dy = int'($urandom_range(0, 2 * r + 4)) - r - 2;
                end
                else if (pick < 9)
                begin
                    // Axis and diagonal directions
                    t  = $urandom_range(0, r + 1);
                    dx = t * (int'($urandom_range(0, 2)) - 1);
                    dy = t * (int'($urandom_range(0, 2)) - 1);
                end
                else
                begin
                    dx = int'($urandom_range(0, COORD_MAX)) - cx;
                    dy = int'($urandom_range(0, COORD_MAX)) - cy;
                end
                send_pixel(on_surface(cx + dx), on_surface(cy + dy));
                n++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: zero radius, full circle around the origin
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        start <= 1'b0;
        wait_idle();

        // Full ring; axis and diagonal pixels, ring edges, an unmapped write
        write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
        configure(100, 100, 50, 0, ANGLE_LIMIT, 1'b0, 32'hFFFF_FFFF);
        send_pixel(100, 100);
        send_pixel(150, 100);
        send_pixel(100, 150);
        send_pixel(50, 100);
        send_pixel(100, 50);
        send_pixel(135, 135);
        send_pixel(65, 135);
        send_pixel(65, 65);
        send_pixel(135, 65);
        send_pixel(149, 100);
        send_pixel(151, 100);
        start <= 1'b0;
        wait_idle();

        // Center off the surface, largest radius, filled quarter
        configure(-4096, COORD_MAX, COORD_MAX, 0, 90, 1'b1, 32'h0123_4567);
        send_pixel(0, COORD_MAX);
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(COORD_MAX, 0);
        send_pixel(1, 2000);
        start <= 1'b0;
        wait_idle();

        // Saturated angle registers leave only angle zero
        configure(2000, 2000, 10, 511, 400, 1'b1, 32'hA5A5_5A5A);
        send_pixel(2005, 2000);
        send_pixel(2000, 2000);
        send_pixel(2000, 2005);
        start <= 1'b0;
        wait_idle();

        // Start above end: empty sector
        configure(2000, 2000, 10, 200, 100, 1'b1, 32'hA5A5_5A5A);
        send_pixel(2005, 2000);
        start <= 1'b0;
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_phase(PHASE_PIXELS);
            wait_idle();
        end

        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (sb.fails == 0 && sb.expected_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
